// ----- rtl/mp4bld_pkg.sv -----
// Shared types and constants for the MP4 box layout detector.
package mp4bld_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic       decided;
		logic [1:0] layout;
	} out_beat_t;

	localparam logic [1:0] LAYOUT_UNKNOWN     = 2'd0;
	localparam logic [1:0] LAYOUT_FRAGMENTED  = 2'd1;
	localparam logic [1:0] LAYOUT_REGULAR     = 2'd2;
	localparam logic [1:0] LAYOUT_LARGE_FRONT = 2'd3;

	localparam logic [31:0] TYPE_MOOV    = 32'h6D6F6F76;
	localparam logic [31:0] TYPE_MOOF    = 32'h6D6F6F66;
	localparam logic [31:0] TYPE_MDAT    = 32'h6D646174;
	localparam logic [31:0] PATTERN_MVEX = 32'h6D766578;

	localparam logic [4:0]  HOLD_BYTES      = 5'd16;
	localparam logic [31:0] THRESHOLD_RESET = 32'd2097152;

endpackage

// ----- rtl/mp4_box_layout_detector_top.sv -----
// Top level of the MP4 box layout detector: handshakes, threshold register, parser.
// Pipeline: an accepted input beat is held in the input register and feeds the parse logic,
// which loads its result into the result register when that register is free.
// Throughput: one byte per cycle, sustained while the output is not stalled.
// Reset: arst_n clears all parse state and pipeline valids and loads the large movie
// threshold with 2097152; the block is ready for bytes as soon as reset is released.
module mp4_box_layout_detector_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mp4bld_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mp4bld_pkg::out_beat_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [31:0]           cfg_data
);
	import mp4bld_pkg::*;

	logic        valid_s1;
	in_beat_t    beat_s1;
	logic        out_valid_q;
	out_beat_t   out_q;
	logic [31:0] threshold_q;
	logic        out_free;
	logic        step;
	out_beat_t   result;

	// The result register can load when empty or when its beat leaves this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	mp4bld_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.beat      (beat_s1),
		.threshold (threshold_q),
		.result    (result)
	);

	a_last_decided: assert property (@(posedge clk) disable iff (!arst_n)
		step && beat_s1.last_byte |=> out_valid_q && out_q.decided)
		else $error("final byte of a buffer did not give a decided result");

	a_undecided_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.decided |-> out_q.layout == LAYOUT_UNKNOWN)
		else $error("undecided result carries a layout");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(beat_s1))
		else $error("input stage beat lost while the result register was full");

endmodule

// ----- rtl/mp4bld_parser.sv -----
// Box header walker: parse state and the per-byte next-state and verdict logic.
module mp4bld_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  mp4bld_pkg::in_beat_t  beat,
	input  logic [31:0]           threshold,
	output mp4bld_pkg::out_beat_t result
);
	import mp4bld_pkg::*;

	logic [3:0]  hdr_idx_q, hdr_idx_n;
	logic [63:0] box_size_q, box_size_n;
	logic [31:0] box_type_q, box_type_n;
	logic [63:0] left_q, left_n;
	logic        saw_movie_q, saw_movie_n;
	logic        in_movie_q, in_movie_n;
	logic [31:0] window_q, window_n;
	logic [2:0]  fill_q, fill_n;
	logic [1:0]  verdict_q, verdict_n;
	logic        fixed_q, fixed_n;
	logic [4:0]  seen_q, seen_n;

	always_comb begin
		logic [7:0]  b;
		logic [63:0] size_base;
		logic [63:0] body;
		logic        hit;
		logic        advance;
		logic        fin;
		logic        fin_long;
		logic        ready;

		b           = beat.data_byte;
		size_base   = '0;
		body        = '0;
		hit         = 1'b0;
		advance     = 1'b1;
		fin         = 1'b0;
		fin_long    = 1'b0;
		ready       = 1'b0;
		hdr_idx_n   = hdr_idx_q;
		box_size_n  = box_size_q;
		box_type_n  = box_type_q;
		left_n      = left_q;
		saw_movie_n = saw_movie_q;
		in_movie_n  = in_movie_q;
		window_n    = window_q;
		fill_n      = fill_q;
		verdict_n   = verdict_q;
		fixed_n     = fixed_q;
		seen_n      = (seen_q < HOLD_BYTES) ? seen_q + 5'd1 : seen_q;

		if (!fixed_q) begin
			if (left_q != 64'd0) begin
				// Body byte: skip it, scanning movie payload for the extends pattern.
				left_n = left_q - 64'd1;
				if (in_movie_q) begin
					window_n = {window_q[23:0], b};
					fill_n   = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
					if (fill_n >= 3'd4 && window_n == PATTERN_MVEX) begin
						fixed_n   = 1'b1;
						verdict_n = LAYOUT_FRAGMENTED;
						hit       = 1'b1;
					end
				end
				if (!hit && left_n == 64'd0) begin
					in_movie_n = 1'b0;
					fill_n     = 3'd0;
					window_n   = '0;
				end
			end else begin
				if (hdr_idx_q < 4'd4) begin
					size_base  = (hdr_idx_q == 4'd0) ? 64'd0 : box_size_q;
					box_size_n = {size_base[55:0], b};
					if (hdr_idx_q == 4'd3 && box_size_n != 64'd1 && box_size_n < 64'd8) begin
						fixed_n   = 1'b1;
						verdict_n = LAYOUT_UNKNOWN;
						advance   = 1'b0;
					end
				end else if (hdr_idx_q < 4'd8) begin
					box_type_n = {box_type_q[23:0], b};
					if (hdr_idx_q == 4'd7 && box_size_q != 64'd1) begin
						fin     = 1'b1;
						advance = 1'b0;
					end
				end else begin
					size_base  = (hdr_idx_q == 4'd8) ? 64'd0 : box_size_q;
					box_size_n = {size_base[55:0], b};
					if (hdr_idx_q == 4'd15) begin
						advance = 1'b0;
						if (box_size_n < 64'd16) begin
							fixed_n   = 1'b1;
							verdict_n = LAYOUT_UNKNOWN;
						end else begin
							fin      = 1'b1;
							fin_long = 1'b1;
						end
					end
				end
				if (advance) begin
					hdr_idx_n = hdr_idx_q + 4'd1;
				end
				if (fin) begin
					body       = box_size_n - (fin_long ? 64'd16 : 64'd8);
					hdr_idx_n  = 4'd0;
					in_movie_n = 1'b0;
					window_n   = '0;
					fill_n     = 3'd0;
					if (box_type_n == TYPE_MOOV) begin
						saw_movie_n = 1'b1;
						if (box_size_n >= {32'd0, threshold}) begin
							fixed_n   = 1'b1;
							verdict_n = LAYOUT_LARGE_FRONT;
						end else begin
							in_movie_n = (body != 64'd0);
							left_n     = body;
						end
					end else if (box_type_n == TYPE_MOOF) begin
						fixed_n   = 1'b1;
						verdict_n = saw_movie_q ? LAYOUT_FRAGMENTED : LAYOUT_REGULAR;
					end else if (box_type_n == TYPE_MDAT) begin
						fixed_n   = 1'b1;
						verdict_n = LAYOUT_REGULAR;
					end else begin
						left_n = body;
					end
				end
			end
		end

		ready          = fixed_n && (seen_n >= HOLD_BYTES);
		result.decided = beat.last_byte | ready;
		result.layout  = ready ? verdict_n : LAYOUT_UNKNOWN;

		// The final byte of a buffer returns the walker to offset zero.
		if (beat.last_byte) begin
			hdr_idx_n   = '0;
			box_size_n  = '0;
			box_type_n  = '0;
			left_n      = '0;
			saw_movie_n = 1'b0;
			in_movie_n  = 1'b0;
			window_n    = '0;
			fill_n      = '0;
			verdict_n   = LAYOUT_UNKNOWN;
			fixed_n     = 1'b0;
			seen_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q   <= '0;
			box_size_q  <= '0;
			box_type_q  <= '0;
			left_q      <= '0;
			saw_movie_q <= 1'b0;
			in_movie_q  <= 1'b0;
			window_q    <= '0;
			fill_q      <= '0;
			verdict_q   <= LAYOUT_UNKNOWN;
			fixed_q     <= 1'b0;
			seen_q      <= '0;
		end else if (step) begin
			hdr_idx_q   <= hdr_idx_n;
			box_size_q  <= box_size_n;
			box_type_q  <= box_type_n;
			left_q      <= left_n;
			saw_movie_q <= saw_movie_n;
			in_movie_q  <= in_movie_n;
			window_q    <= window_n;
			fill_q      <= fill_n;
			verdict_q   <= verdict_n;
			fixed_q     <= fixed_n;
			seen_q      <= seen_n;
		end
	end

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= HOLD_BYTES)
		else $error("byte counter ran past the hold count");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd4)
		else $error("payload window fill out of range");

	a_body_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 64'd0 |-> hdr_idx_q == 4'd0)
		else $error("header position moved while inside a box body");

	a_movie_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_movie_q && !fixed_q |-> left_q != 64'd0)
		else $error("movie payload scan active with no body bytes left");

	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && fixed_q && !beat.last_byte |=> fixed_q && $stable(verdict_q))
		else $error("fixed verdict changed before the end of the buffer");

endmodule
